### design/rsw_pkg.sv
package rsw_pkg;

  localparam int ENTRIES = 32;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_WB     = 2'd2,
    FUNC_ISSUE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CLS_REG_IMM  = 2'd0,
    CLS_REG_REG  = 2'd1,
    CLS_BASE_OFF = 2'd2,
    CLS_UNKNOWN  = 2'd3
  } op_class_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_UNKNOWN = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [31:0] insn;
    logic [4:0]  rob;
    logic [31:0] imm;
    logic        wait_a;
    logic [4:0]  tag_a;
    logic [31:0] value_a;
    logic        wait_b;
    logic [4:0]  tag_b;
    logic [31:0] value_b;
  } entry_t;

  typedef struct packed {
    logic        clear;
    logic        insert;
    logic        wb;
    logic        issue;
    logic [4:0]  wb_tag;
    logic [31:0] wb_value;
  } cmd_t;

  typedef struct packed {
    logic take;
  } chain_t;

endpackage

### design/rsw_cell.sv
module rsw_cell import rsw_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cmd_t   cmd,
  input  entry_t new_entry,
  input  chain_t ins_in,
  output chain_t ins_out,
  input  chain_t iss_in,
  output chain_t iss_out,
  output logic   valid,
  output logic   picked,
  output entry_t data
);

  logic   valid_r, valid_nxt;
  entry_t ent_r, ent_nxt;
  logic   ready;
  logic   do_ins;

  assign ready  = valid_r && !ent_r.wait_a && !ent_r.wait_b;
  assign do_ins = cmd.insert && ins_in.take && !valid_r;
  assign ins_out.take = ins_in.take && valid_r;
  assign picked = cmd.issue && iss_in.take && ready;
  assign iss_out.take = iss_in.take && !ready;
  assign valid = valid_r;
  assign data  = ent_r;

  always_comb begin
    valid_nxt = valid_r;
    ent_nxt   = ent_r;
    if (cmd.clear) begin
      valid_nxt = 1'b0;
    end else if (do_ins) begin
      valid_nxt = 1'b1;
      ent_nxt   = new_entry;
    end else if (picked) begin
      valid_nxt = 1'b0;
    end else if (cmd.wb && valid_r) begin
      if (ent_r.wait_a && ent_r.tag_a == cmd.wb_tag) begin
        ent_nxt.wait_a  = 1'b0;
        ent_nxt.value_a = cmd.wb_value;
      end
      if (ent_r.wait_b && ent_r.tag_b == cmd.wb_tag) begin
        ent_nxt.wait_b  = 1'b0;
        ent_nxt.value_b = cmd.wb_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    ent_r <= ent_nxt;
  end

endmodule

### design/reservation_station_wakeup_issue_core.sv
// Reservation station with tag wakeup and lowest-slot issue.
// Assert start with in_func and the other in_ fields while busy is low;
// the command is transferred at that edge. Clear empties every slot,
// insert fills the lowest free slot, writeback wakes matching sources,
// and issue frees the lowest ready slot and forms the ALU operands.
// Each command produces exactly one result, shown on the out_ ports
// for one cycle with out_valid high, in the DONE state that follows SCAN.
// busy is high in the SCAN and DONE states, so a new command is taken
// only after the last result has been shown. The slots are a row of cells; the
// free-slot and ready-slot priority chains ripple through the row in the
// cycle after the transfer, and the selected slot's data are muxed out
// and registered in the same cycle.
// The receiver cannot stall: a result is present for one cycle only.
// Reset empties every slot and returns the control to idle.
module reservation_station_wakeup_issue_core import rsw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_op_class,
  input  logic [31:0] in_insn,
  input  logic [4:0]  in_rob_index,
  input  logic signed [31:0] in_imm,
  input  logic        in_wait_a,
  input  logic [4:0]  in_tag_a,
  input  logic [31:0] in_value_a,
  input  logic        in_wait_b,
  input  logic [4:0]  in_tag_b,
  input  logic [31:0] in_value_b,
  output logic        out_valid,
  output logic        out_issued,
  output logic [31:0] out_lhs,
  output logic [31:0] out_rhs,
  output logic [31:0] out_insn,
  output logic [4:0]  out_rob_index,
  output logic        out_full_res,
  output logic [1:0]  out_error
);

  state_t state_r, state_nxt;
  func_t  func_r;
  entry_t new_r;
  cmd_t   cmd;

  chain_t ins_c [ENTRIES+1];
  chain_t iss_c [ENTRIES+1];
  logic   [ENTRIES-1:0] valid_v, picked_v;
  entry_t data_v [ENTRIES];

  logic        issued_r;
  logic [31:0] lhs_r, rhs_r, insn_r;
  logic [4:0]  rob_r;
  logic        full_r;
  logic [1:0]  err_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (state_r == ST_IDLE && start) begin
      func_r        <= func_t'(in_func);
      new_r.cls     <= in_op_class;
      new_r.insn    <= in_insn;
      new_r.rob     <= in_rob_index;
      new_r.imm     <= in_imm;
      new_r.wait_a  <= in_wait_a;
      new_r.tag_a   <= in_tag_a;
      new_r.value_a <= in_value_a;
      new_r.wait_b  <= in_wait_b;
      new_r.tag_b   <= in_tag_b;
      new_r.value_b <= in_value_b;
    end
  end

  always_comb begin
    cmd.clear    = (state_r == ST_SCAN) && (func_r == FUNC_CLEAR);
    cmd.insert   = (state_r == ST_SCAN) && (func_r == FUNC_INSERT);
    cmd.wb       = (state_r == ST_SCAN) && (func_r == FUNC_WB);
    cmd.issue    = (state_r == ST_SCAN) && (func_r == FUNC_ISSUE);
    cmd.wb_tag   = new_r.tag_a;
    cmd.wb_value = new_r.value_a;
  end

  assign ins_c[0].take = 1'b1;
  assign iss_c[0].take = 1'b1;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    rsw_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .new_entry (new_r),
      .ins_in    (ins_c[g]),
      .ins_out   (ins_c[g+1]),
      .iss_in    (iss_c[g]),
      .iss_out   (iss_c[g+1]),
      .valid     (valid_v[g]),
      .picked    (picked_v[g]),
      .data      (data_v[g])
    );
  end

  entry_t sel;
  logic   any_pick;
  always_comb begin
    sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (picked_v[i]) sel = data_v[i];
    end
    any_pick = |picked_v;
  end

  logic [ENTRIES-1:0] ins_take_v;
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ins_take_v[i] = ins_c[i].take;
    end
  end

  logic full_after;
  always_comb begin
    case (func_r)
      FUNC_CLEAR:  full_after = 1'b0;
      FUNC_INSERT: full_after = &(valid_v | ins_take_v);
      FUNC_ISSUE:  full_after = (&valid_v) && !any_pick;
      default:     full_after = &valid_v;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      issued_r <= 1'b0;
      lhs_r    <= '0;
      rhs_r    <= '0;
      insn_r   <= '0;
      rob_r    <= '0;
      err_r    <= ERR_NONE;
      full_r   <= full_after;
      if (func_r == FUNC_INSERT && ins_c[ENTRIES].take) begin
        err_r <= ERR_FULL;
      end
      if (any_pick) begin
        insn_r <= sel.insn;
        rob_r  <= sel.rob;
        if (sel.cls == CLS_UNKNOWN) begin
          err_r <= ERR_UNKNOWN;
        end else begin
          issued_r <= 1'b1;
          lhs_r    <= sel.value_a;
          rhs_r    <= (sel.cls == CLS_REG_REG) ? sel.value_b : sel.imm;
        end
      end
    end
  end

  assign out_issued    = issued_r;
  assign out_lhs       = lhs_r;
  assign out_rhs       = rhs_r;
  assign out_insn      = insn_r;
  assign out_rob_index = rob_r;
  assign out_full_res  = full_r;
  assign out_error     = err_r;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rsw_pkg::*;

  typedef struct {
    func_t       func;
    op_class_t   cls;
    logic [31:0] insn;
    logic [4:0]  rob;
    logic [31:0] imm;
    logic        wait_a;
    logic [4:0]  tag_a;
    logic [31:0] value_a;
    logic        wait_b;
    logic [4:0]  tag_b;
    logic [31:0] value_b;
  } cmd_s;

  typedef struct {
    logic        issued;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] insn;
    logic [4:0]  rob;
    logic        full;
    err_t        err;
  } res_s;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [1:0] in_op_class = '0;
  logic [31:0] in_insn = '0;
  logic [4:0] in_rob_index = '0;
  logic signed [31:0] in_imm = '0;
  logic in_wait_a = 1'b0;
  logic [4:0] in_tag_a = '0;
  logic [31:0] in_value_a = '0;
  logic in_wait_b = 1'b0;
  logic [4:0] in_tag_b = '0;
  logic [31:0] in_value_b = '0;
  logic out_valid, out_issued, out_full_res;
  logic [31:0] out_lhs, out_rhs, out_insn;
  logic [4:0] out_rob_index;
  logic [1:0] out_error;

  reservation_station_wakeup_issue_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cmd_s pending_cmds[$];
  res_s expected_results[$];
  entry_t slots[ENTRIES];
  logic slot_used[ENTRIES] = '{default: 1'b0};
  int errors = 0;
  int cycles = 0;
  int idle_left = 0;
  bit quiet_tail = 0;
  bit stim_done = 0;

  function automatic res_s station_step(cmd_s c);
    res_s r;
    int k;
    bit all;
    r.issued = 1'b0;
    r.lhs = '0;
    r.rhs = '0;
    r.insn = '0;
    r.rob = '0;
    r.full = 1'b0;
    r.err = ERR_NONE;
    case (c.func)
      FUNC_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      end
      FUNC_INSERT: begin
        k = -1;
        for (int i = 0; i < ENTRIES; i++) if (!slot_used[i] && k < 0) k = i;
        if (k < 0) begin
          r.err = ERR_FULL;
        end else begin
          slot_used[k] = 1'b1;
          slots[k] = '{c.cls, c.insn, c.rob, c.imm, c.wait_a, c.tag_a, c.value_a,
                       c.wait_b, c.tag_b, c.value_b};
        end
      end
      FUNC_WB: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i]) begin
            if (slots[i].wait_a && slots[i].tag_a == c.tag_a) begin
              slots[i].wait_a = 1'b0;
              slots[i].value_a = c.value_a;
            end
            if (slots[i].wait_b && slots[i].tag_b == c.tag_a) begin
              slots[i].wait_b = 1'b0;
              slots[i].value_b = c.value_a;
            end
          end
        end
      end
      default: begin
        k = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (k < 0 && slot_used[i] && !slots[i].wait_a && !slots[i].wait_b) k = i;
        if (k >= 0) begin
          slot_used[k] = 1'b0;
          r.insn = slots[k].insn;
          r.rob = slots[k].rob;
          case (op_class_t'(slots[k].cls))
            CLS_REG_IMM, CLS_BASE_OFF: begin
              r.issued = 1'b1;
              r.lhs = slots[k].value_a;
              r.rhs = slots[k].imm;
            end
            CLS_REG_REG: begin
              r.issued = 1'b1;
              r.lhs = slots[k].value_a;
              r.rhs = slots[k].value_b;
            end
            default: r.err = ERR_UNKNOWN;
          endcase
        end
      end
    endcase
    all = 1;
    for (int i = 0; i < ENTRIES; i++) if (!slot_used[i]) all = 0;
    r.full = all;
    return r;
  endfunction

  function automatic cmd_s random_cmd(func_t f);
    cmd_s c;
    c.func = f;
    c.cls = op_class_t'($urandom_range(0, 3));
    c.insn = $urandom;
    c.rob = 5'($urandom);
    c.imm = $urandom;
    c.wait_a = 1'($urandom);
    c.tag_a = 5'($urandom_range(0, 7));
    c.value_a = $urandom;
    c.wait_b = 1'($urandom);
    c.tag_b = 5'($urandom_range(0, 7));
    c.value_b = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      c.tag_a = 5'($urandom);
      c.tag_b = 5'($urandom);
    end
    return c;
  endfunction

  always @(posedge clk) begin
    cmd_s c;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        c = pending_cmds.pop_front();
        expected_results.push_back(station_step(c));
      end
      if (start && !busy || !start) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
          idle_left <= $urandom_range(1, 15) - 1;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds[0];
          start <= 1'b1;
          in_func <= c.func;
          in_op_class <= c.cls;
          in_insn <= c.insn;
          in_rob_index <= c.rob;
          in_imm <= c.imm;
          in_wait_a <= c.wait_a;
          in_tag_a <= c.tag_a;
          in_value_a <= c.value_a;
          in_wait_b <= c.wait_b;
          in_tag_b <= c.tag_b;
          in_value_b <= c.value_b;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_s e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result transfer with none expected", $time);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_issued !== e.issued || out_lhs !== e.lhs || out_rhs !== e.rhs ||
            out_insn !== e.insn || out_rob_index !== e.rob ||
            out_full_res !== e.full || out_error !== e.err) begin
          $display("%0t: expected iss=%0d lhs=%h rhs=%h insn=%h rob=%0d full=%0d err=%0d",
                   $time, e.issued, e.lhs, e.rhs, e.insn, e.rob, e.full, e.err);
          $display("%0t: actual   iss=%0d lhs=%h rhs=%h insn=%h rob=%0d full=%0d err=%0d",
                   $time, out_issued, out_lhs, out_rhs, out_insn, out_rob_index,
                   out_full_res, out_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 200000) begin
      $display("** reservation_station_wakeup_issue_core: FAILED **");
      $finish;
    end
  end

  initial begin
    cmd_s c;
    func_t f;
    int n;
    // Directed part: edge values, every class, fill past full, wakeup of both sources.
    c = random_cmd(FUNC_INSERT);
    c.cls = CLS_REG_IMM; c.wait_a = 0; c.wait_b = 0;
    c.insn = '1; c.rob = '1; c.imm = 32'h8000_0000; c.value_a = '1; c.value_b = '0;
    pending_cmds.push_back(c);
    c.cls = CLS_REG_REG; c.imm = 32'h7fff_ffff; c.insn = '0; c.rob = '0; c.value_a = '0;
    c.value_b = '1;
    pending_cmds.push_back(c);
    c.cls = CLS_BASE_OFF; pending_cmds.push_back(c);
    c.cls = CLS_UNKNOWN; pending_cmds.push_back(c);
    c.cls = CLS_REG_REG; c.wait_a = 1; c.wait_b = 1; c.tag_a = 5'd31; c.tag_b = 5'd31;
    pending_cmds.push_back(c);
    for (int i = 0; i < 6; i++) pending_cmds.push_back(random_cmd(FUNC_ISSUE));
    c = random_cmd(FUNC_WB); c.tag_a = 5'd31; c.value_a = 32'hdead_beef;
    pending_cmds.push_back(c);
    pending_cmds.push_back(random_cmd(FUNC_ISSUE));
    for (int i = 0; i < 34; i++) pending_cmds.push_back(random_cmd(FUNC_INSERT));
    pending_cmds.push_back(random_cmd(FUNC_CLEAR));
    pending_cmds.push_back(random_cmd(FUNC_ISSUE));
    // Random part: mostly inserts, wakeups and issues, with occasional clears.
    for (int i = 0; i < 1000; i++) begin
      n = $urandom_range(0, 99);
      if (n < 2) f = FUNC_CLEAR;
      else if (n < 40) f = FUNC_INSERT;
      else if (n < 70) f = FUNC_WB;
      else f = FUNC_ISSUE;
      pending_cmds.push_back(random_cmd(f));
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() < 100);
    quiet_tail = 1;
    wait (pending_cmds.size() == 0 && expected_results.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** reservation_station_wakeup_issue_core: PASSED **");
    end else begin
      $display("** reservation_station_wakeup_issue_core: FAILED **");
    end
    $finish;
  end
endmodule

### reservation_station_wakeup_issue_core.f
design/rsw_pkg.sv
design/rsw_cell.sv
design/reservation_station_wakeup_issue_core.sv
test/tb_top.sv
